// ===== hw/rtl/stbm_pkg.sv =====
// Shared types and constants of the split-tree bucket map.
// Used by stbm_ctrl, stbm_dp and split_tree_bucket_map_top; depends on nothing.
package stbm_pkg;

    localparam int MAX_SERVERS = 256;
    localparam int WORD_BITS   = 32;
    localparam int NUM_WORDS   = (MAX_SERVERS + WORD_BITS - 1) / WORD_BITS;
    localparam int MAP_BITS    = NUM_WORDS * WORD_BITS;
    localparam int MAP_AW      = $clog2(MAP_BITS);
    localparam int ADDR_W      = MAP_AW + 1;
    localparam int WORD_AW     = $clog2(WORD_BITS);
    localparam int WALK_W      = $clog2(MAP_AW + 1);

    // Fixed field widths.
    localparam int CMD_W    = 3;
    localparam int HASH_W   = 64;
    localparam int CNT_W    = 9;
    localparam int WIDX_W   = 3;
    localparam int LEVEL_W  = 5;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 8;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 9;

    // Input request packing, lowest bit first.
    localparam int F_CMD_LSB     = 0;
    localparam int F_HASH_LSB    = F_CMD_LSB + CMD_W;
    localparam int F_QUERY_LSB   = F_HASH_LSB + HASH_W;
    localparam int F_WIDX_LSB    = F_QUERY_LSB + CNT_W;
    localparam int F_PWORD_LSB   = F_WIDX_LSB + WIDX_W;
    localparam int F_PCOUNT_LSB  = F_PWORD_LSB + WORD_BITS;
    localparam int F_PSERVER_LSB = F_PCOUNT_LSB + CNT_W;
    localparam int IN_BITS       = F_PSERVER_LSB + CNT_W;
    localparam int IN_TDATA_W    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = 16;

    typedef enum logic [CMD_W-1:0] {
        OP_INIT   = 3'd0,
        OP_LOOKUP = 3'd1,
        OP_TEST   = 3'd2,
        OP_SPLIT  = 3'd3,
        OP_MERGE  = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_BUCKET = 2'd1,
        ST_NO_SPLIT  = 2'd2,
        ST_REFUSED   = 2'd3
    } t_status;

    typedef enum logic [CFG_AW-1:0] {
        CFG_SERVER_COUNT   = 2'd0,
        CFG_OWN_SERVER     = 2'd1,
        CFG_INITIAL_ACTIVE = 2'd2
    } t_cfg_idx;

    // Source of the single bitmap read port.
    typedef enum logic [2:0] {
        A_QUERY  = 3'd0,
        A_SPLIT  = 3'd1,
        A_OWN    = 3'd2,
        A_WALK   = 3'd3,
        A_LOOKUP = 3'd4
    } t_asel;

    typedef struct packed {
        logic    capture;
        logic    do_init;
        logic    do_split;
        logic    do_merge;
        logic    walk_load_h;
        logic    walk_load_len;
        logic    walk_inc;
        logic    walk_dec;
        logic    level_set;
        logic    level_none;
        logic    set_active;
        logic    set_index;
        logic    set_status;
        t_status status;
        t_asel   asel;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        t_op  opcode;
        logic rd_bit;
        logic split_ok;
        logic merge_ok;
        logic own_ok;
        logic walk_zero;
    } t_stat;

endpackage

// ===== hw/rtl/stbm_dp.sv =====
// Datapath of the split-tree bucket map: configuration, bitmap, branch level,
// walk counter, result and output registers. Depends on stbm_pkg.
module stbm_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [stbm_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  logic [stbm_pkg::CFG_DW-1:0]      i_cfg_wdata,
    input  logic [stbm_pkg::IN_TDATA_W-1:0]  i_in_data,
    input  stbm_pkg::t_cmd                   i_cmd,
    output stbm_pkg::t_stat                  o_stat,
    output logic [stbm_pkg::OUT_TDATA_W-1:0] o_out_data
);
    import stbm_pkg::*;

    logic [CNT_W-1:0]     r_server_count;
    logic [CNT_W-1:0]     r_own_server;
    logic [CNT_W-1:0]     r_initial_active;

    t_op                  r_op;
    logic [MAP_AW-1:0]    r_hash;
    logic [CNT_W-1:0]     r_query;
    logic [WIDX_W-1:0]    r_widx;
    logic [WORD_BITS-1:0] r_pword;
    logic [CNT_W-1:0]     r_pcount;
    logic [CNT_W-1:0]     r_pserver;

    logic [MAP_BITS-1:0]  r_map;
    logic [LEVEL_W-1:0]   r_level;
    logic [WALK_W-1:0]    r_walk;

    t_status              r_status;
    logic [INDEX_W-1:0]   r_index;
    logic                 r_active;
    logic [OUT_TDATA_W-1:0] r_out;

    logic [CNT_W-1:0]     n_eff;
    logic [CNT_W-1:0]     n_eff_m1;
    logic [WALK_W-1:0]    height;
    logic [ADDR_W-1:0]    cap;
    logic [WALK_W-1:0]    cap_words;
    logic                 own_nonneg;
    logic [ADDR_W-1:0]    own_addr;
    logic [ADDR_W-1:0]    pow_walk;
    logic [ADDR_W-1:0]    walk_addr;
    logic [ADDR_W-1:0]    split_node;
    logic [ADDR_W-1:0]    lookup_node;
    logic                 split_ok;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 rd_bit;
    logic [CNT_W-1:0]     init_k;
    logic [MAP_BITS-1:0]  init_mask;

    function automatic logic [WALK_W-1:0] f_bitlen(input logic [MAP_AW-1:0] v);
        logic [WALK_W-1:0] len;
        len = '0;
        for (int i = 0; i < MAP_AW; i++) begin
            if (v[i]) len = WALK_W'(i + 1);
        end
        return len;
    endfunction

    // Effective count, tree height and addressable capacity.
    always_comb begin
        if (r_server_count == '0) begin
            n_eff = CNT_W'(1);
        end else if (r_server_count > CNT_W'(MAX_SERVERS)) begin
            n_eff = CNT_W'(MAX_SERVERS);
        end else begin
            n_eff = r_server_count;
        end
    end

    assign n_eff_m1  = n_eff - CNT_W'(1);
    assign height    = f_bitlen(n_eff_m1[MAP_AW-1:0]);
    assign cap       = (height <= WALK_W'(WORD_AW)) ? ADDR_W'(WORD_BITS)
                                                     : (ADDR_W'(1) << height);
    assign cap_words = cap[ADDR_W-1:WORD_AW];

    assign own_nonneg  = !r_own_server[CNT_W-1];
    assign own_addr    = {1'b0, r_own_server[MAP_AW-1:0]};
    assign pow_walk    = ADDR_W'(1) << r_walk;
    assign walk_addr   = own_addr + pow_walk;
    assign split_node  = own_addr + (ADDR_W'(1) << r_level[WALK_W-1:0]);
    assign lookup_node = {1'b0, r_hash} & (pow_walk - ADDR_W'(1));

    assign split_ok = own_nonneg && !r_level[LEVEL_W-1]
                   && (r_level[WALK_W-1:0] < height) && (split_node < n_eff);

    always_comb begin
        case (i_cmd.asel)
            A_QUERY:  rd_addr = r_query;
            A_SPLIT:  rd_addr = split_node;
            A_OWN:    rd_addr = own_addr;
            A_WALK:   rd_addr = walk_addr;
            A_LOOKUP: rd_addr = lookup_node;
            default:  rd_addr = own_addr;
        endcase
    end

    // Bits beyond capacity read as clear; a tested bucket must also be below the count.
    assign rd_bit = (rd_addr < cap) && ((i_cmd.asel != A_QUERY) || (rd_addr < n_eff))
                 && r_map[rd_addr[MAP_AW-1:0]];

    assign init_k = ((r_initial_active == '0) || (r_initial_active > n_eff))
                  ? n_eff : r_initial_active;

    always_comb begin
        for (int i = 0; i < MAP_BITS; i++) begin
            init_mask[i] = (CNT_W'(i) < init_k);
        end
    end

    assign o_stat.opcode    = r_op;
    assign o_stat.rd_bit    = rd_bit;
    assign o_stat.split_ok  = split_ok;
    assign o_stat.merge_ok  = (r_pcount == r_server_count) && (r_pserver != r_own_server);
    assign o_stat.own_ok    = own_nonneg && (r_own_server < n_eff);
    assign o_stat.walk_zero = (r_walk == '0);

    assign o_out_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_count   <= CNT_W'(1);
            r_own_server     <= '1;
            r_initial_active <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_SERVER_COUNT:   r_server_count   <= i_cfg_wdata;
                CFG_OWN_SERVER:     r_own_server     <= i_cfg_wdata;
                CFG_INITIAL_ACTIVE: r_initial_active <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
        end else if (i_cmd.do_init) begin
            r_map <= init_mask;
        end else if (i_cmd.do_split) begin
            r_map[split_node[MAP_AW-1:0]] <= 1'b1;
        end else if (i_cmd.do_merge && ({1'b0, r_widx} < cap_words)) begin
            r_map[r_widx*WORD_BITS +: WORD_BITS] <=
                r_map[r_widx*WORD_BITS +: WORD_BITS] | r_pword;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '1;
            r_walk  <= '0;
        end else begin
            if (i_cmd.level_set) begin
                r_level <= {1'b0, r_walk};
            end else if (i_cmd.level_none) begin
                r_level <= '1;
            end
            if (i_cmd.walk_load_h) begin
                r_walk <= height;
            end else if (i_cmd.walk_load_len) begin
                r_walk <= f_bitlen(r_own_server[MAP_AW-1:0]);
            end else if (i_cmd.walk_inc) begin
                r_walk <= r_walk + WALK_W'(1);
            end else if (i_cmd.walk_dec) begin
                r_walk <= r_walk - WALK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= t_op'(i_in_data[F_CMD_LSB +: CMD_W]);
            r_hash    <= i_in_data[F_HASH_LSB +: MAP_AW];
            r_query   <= i_in_data[F_QUERY_LSB +: CNT_W];
            r_widx    <= i_in_data[F_WIDX_LSB +: WIDX_W];
            r_pword   <= i_in_data[F_PWORD_LSB +: WORD_BITS];
            r_pcount  <= i_in_data[F_PCOUNT_LSB +: CNT_W];
            r_pserver <= i_in_data[F_PSERVER_LSB +: CNT_W];
            r_status  <= ST_OK;
            r_index   <= '0;
            r_active  <= 1'b0;
        end else begin
            if (i_cmd.set_status) r_status <= i_cmd.status;
            if (i_cmd.set_active) r_active <= rd_bit;
            if (i_cmd.set_index) begin
                r_index <= lookup_node[INDEX_W-1:0];
            end else if (i_cmd.do_split) begin
                r_index <= split_node[INDEX_W-1:0];
            end
        end
        if (i_cmd.load_out) begin
            r_out <= {r_level, r_active, r_index, r_status};
        end
    end

`ifndef ASSERT_OFF
    // A finished walk never leaves the level above the tree's deepest bit.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.level_set |=> (r_level <= LEVEL_W'(MAP_AW)))
        else $error("branch level out of range after walk");

    // The branch level moves only on an explicit recompute.
    a_level_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.level_set || i_cmd.level_none) |=> $stable(r_level))
        else $error("branch level changed without recompute");

    // A split is only committed when the node is legal and still clear.
    a_split_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_split |-> (split_ok && !rd_bit && (i_cmd.asel == A_SPLIT)))
        else $error("split committed on an illegal or active node");
`endif

endmodule

// ===== hw/rtl/stbm_ctrl.sv =====
// Sequencer of the split-tree bucket map: request handshake, command steps and
// the output register's valid flag. Depends on stbm_pkg.
module stbm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  stbm_pkg::t_stat i_stat,
    output stbm_pkg::t_cmd  o_cmd
);
    import stbm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_RC_START,
        S_RC_WALK,
        S_LOOKUP,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    t_cmd   cmd;

    always_comb begin
        cmd         = '0;
        cmd.asel    = A_OWN;
        cmd.status  = ST_OK;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.opcode)
                    OP_INIT: begin
                        cmd.do_init = 1'b1;
                        n_state     = S_RC_START;
                    end
                    OP_LOOKUP: begin
                        cmd.walk_load_h = 1'b1;
                        n_state         = S_LOOKUP;
                    end
                    OP_TEST: begin
                        cmd.asel       = A_QUERY;
                        cmd.set_active = 1'b1;
                        n_state        = S_FINISH;
                    end
                    OP_SPLIT: begin
                        cmd.asel = A_SPLIT;
                        if (i_stat.split_ok && !i_stat.rd_bit) begin
                            cmd.do_split = 1'b1;
                            n_state      = S_RC_START;
                        end else begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_NO_SPLIT;
                            n_state        = S_FINISH;
                        end
                    end
                    OP_MERGE: begin
                        if (i_stat.merge_ok) begin
                            cmd.do_merge = 1'b1;
                            n_state      = S_RC_START;
                        end else begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_REFUSED;
                            n_state        = S_FINISH;
                        end
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_RC_START: begin
                // Own bucket must exist and be active before the level walk starts.
                cmd.asel = A_OWN;
                if (i_stat.own_ok && i_stat.rd_bit) begin
                    cmd.walk_load_len = 1'b1;
                    n_state           = S_RC_WALK;
                end else begin
                    cmd.level_none = 1'b1;
                    n_state        = S_FINISH;
                end
            end
            S_RC_WALK: begin
                cmd.asel = A_WALK;
                if (i_stat.rd_bit) begin
                    cmd.walk_inc = 1'b1;
                end else begin
                    cmd.level_set = 1'b1;
                    n_state       = S_FINISH;
                end
            end
            S_LOOKUP: begin
                cmd.asel = A_LOOKUP;
                if (i_stat.rd_bit) begin
                    cmd.set_index = 1'b1;
                    n_state       = S_FINISH;
                end else if (i_stat.walk_zero) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NO_BUCKET;
                    n_state        = S_FINISH;
                end else begin
                    cmd.walk_dec = 1'b1;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ===== hw/rtl/split_tree_bucket_map_top.sv =====
// Top level of the split-tree bucket map: stream ports, configuration port,
// sequencer and datapath. Depends on stbm_pkg, stbm_ctrl and stbm_dp.
//
//  Channel   | Direction | Handshake                      | Contents
//  s_axis    | in        | s_axis_tvalid / s_axis_tready  | one command request
//  m_axis    | out       | m_axis_tvalid / m_axis_tready  | one result per request
//  cfg       | in        | i_cfg_we (no wait)             | count, own server, init size
//
// A test, an unknown command or a refused split or merge goes from dispatch
// straight to the finish state. A lookup reads one tree level per cycle, from
// the tree height H (up to 8) down toward the root until it hits an active
// bucket. Init and a split or merge that goes through run the branch-level walk,
// one bitmap read per step, as there is a single bitmap read port. A new request
// is taken while the last result waits in the output register. Reset is
// synchronous and active low; it clears the bitmap and sets the branch level to -1.
module split_tree_bucket_map_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [stbm_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  logic [stbm_pkg::CFG_DW-1:0]      i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // command, hash, query_server, word_index, peer_word, peer_server_count,
    // peer_server, zero fill
    input  logic [stbm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status, index, active, own level
    output logic [stbm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import stbm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    stbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    stbm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ===== sim/tb_split_tree_bucket_map_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for split_tree_bucket_map_top: directed and random map commands
// over several register settings, checked against a behavioral bucket map.
// Depends on stbm_pkg and the top-level RTL.
module tb_split_tree_bucket_map_top;
    import stbm_pkg::*;

    localparam int RUN_ITEMS    = 190;
    localparam int NUM_PHASES   = 10;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 3000;

    typedef struct {
        logic [CMD_W-1:0]     cmd;
        logic [HASH_W-1:0]    hash;
        logic [CNT_W-1:0]     query;
        logic [WIDX_W-1:0]    widx;
        logic [WORD_BITS-1:0] pword;
        logic [CNT_W-1:0]     pcount;
        logic [CNT_W-1:0]     pserver;
    } t_map_req;

    typedef struct {
        t_status            status;
        logic [INDEX_W-1:0] index;
        logic               active;
        logic [LEVEL_W-1:0] level;
    } t_map_resp;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_AW-1:0]      cfg_addr = '0;
    logic [CFG_DW-1:0]      cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [IN_TDATA_W-1:0]  s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_data;

    split_tree_bucket_map_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data)
    );

    t_map_req  pending_requests[$];
    t_map_resp expected_results[$];
    t_map_req  req_on_bus;
    int        send_idle = 0;
    int        recv_idle = 0;
    int        errors = 0;
    int        quiet_cycles = 0;

    // Behavioral copy of the bucket map and its registers.
    logic [WORD_BITS-1:0] map_words [NUM_WORDS];
    int                   map_level = -1;
    logic [CNT_W-1:0]     reg_count = 9'd1;
    logic [CNT_W-1:0]     reg_own = 9'h1FF;
    logic [CNT_W-1:0]     reg_init = 9'd0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int map_count();
        if (reg_count == 0) return 1;
        if (reg_count > MAX_SERVERS) return MAX_SERVERS;
        return int'(reg_count);
    endfunction

    function automatic int map_height();
        int h;
        h = 0;
        while ((1 << h) < map_count()) h++;
        return h;
    endfunction

    function automatic int map_capacity();
        int c;
        c = 1 << map_height();
        if (c < WORD_BITS) c = WORD_BITS;
        if (c > MAP_BITS) c = MAP_BITS;
        return c;
    endfunction

    function automatic logic map_bit(int i);
        if (i >= map_capacity()) return 1'b0;
        return map_words[i / WORD_BITS][i % WORD_BITS];
    endfunction

    function automatic void map_set(int i);
        if (i < map_capacity()) map_words[i / WORD_BITS][i % WORD_BITS] = 1'b1;
    endfunction

    // Start at the bit length of the own bucket and climb while its child is active.
    function automatic void refresh_branch_level();
        int s;
        int lv;
        s = int'($signed(reg_own));
        lv = 0;
        if (s < 0 || s >= map_count() || !map_bit(s)) begin
            map_level = -1;
            return;
        end
        while ((s >> lv) != 0) lv++;
        while (lv < 20 && map_bit(s + (1 << lv))) lv++;
        map_level = lv;
    endfunction

    function automatic t_map_resp predict_map_result(t_map_req r);
        t_map_resp res;
        int        n, h, s, k, node, lv;
        n = map_count();
        h = map_height();
        res.status = ST_OK;
        res.index  = '0;
        res.active = 1'b0;
        case (r.cmd)
            OP_INIT: begin
                k = int'(reg_init);
                if (k == 0 || k > n) k = n;
                foreach (map_words[i]) map_words[i] = '0;
                for (int i = 0; i < k; i++) map_set(i);
                refresh_branch_level();
            end
            OP_LOOKUP: begin
                res.status = ST_NO_BUCKET;
                for (lv = h; lv >= 0; lv--) begin
                    node = int'(r.hash & ((64'd1 << lv) - 64'd1));
                    if (map_bit(node)) begin
                        res.status = ST_OK;
                        res.index  = INDEX_W'(node);
                        break;
                    end
                end
            end
            OP_TEST: begin
                res.active = (int'(r.query) < n) && map_bit(int'(r.query));
            end
            OP_SPLIT: begin
                s = int'($signed(reg_own));
                if (s < 0 || map_level < 0 || map_level >= h) begin
                    res.status = ST_NO_SPLIT;
                end else begin
                    node = s + (1 << map_level);
                    if (node >= n || map_bit(node)) begin
                        res.status = ST_NO_SPLIT;
                    end else begin
                        map_set(node);
                        refresh_branch_level();
                        res.index = INDEX_W'(node);
                    end
                end
            end
            OP_MERGE: begin
                if (r.pcount != reg_count || $signed(r.pserver) == $signed(reg_own)) begin
                    res.status = ST_REFUSED;
                end else begin
                    if (int'(r.widx) < map_capacity() / WORD_BITS)
                        map_words[r.widx] = map_words[r.widx] | r.pword;
                    refresh_branch_level();
                end
            end
            default: begin
            end
        endcase
        res.level = LEVEL_W'(map_level);
        return res;
    endfunction

    task automatic push_req(logic [CMD_W-1:0] c, logic [HASH_W-1:0] hv, logic [CNT_W-1:0] q,
                            logic [WIDX_W-1:0] w, logic [WORD_BITS-1:0] pw,
                            logic [CNT_W-1:0] pc, logic [CNT_W-1:0] ps);
        t_map_req r;
        r.cmd     = c;
        r.hash    = hv;
        r.query   = q;
        r.widx    = w;
        r.pword   = pw;
        r.pcount  = pc;
        r.pserver = ps;
        pending_requests.push_back(r);
    endtask

    // Registers change only while no request is in flight, so the model copy is
    // updated together with the write.
    task automatic set_config(logic [CNT_W-1:0] cnt, logic [CNT_W-1:0] own,
                              logic [CNT_W-1:0] init_n);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_SERVER_COUNT;
        cfg_wdata <= cnt;
        reg_count = cnt;
        @(posedge i_clk);
        cfg_addr  <= CFG_OWN_SERVER;
        cfg_wdata <= own;
        reg_own = own;
        @(posedge i_clk);
        cfg_addr  <= CFG_INITIAL_ACTIVE;
        cfg_wdata <= init_n;
        reg_init = init_n;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) expected_results.push_back(predict_map_result(req_on_bus));
            if (!s_valid || s_ready) begin
                if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                    req_on_bus = pending_requests.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= IN_TDATA_W'({req_on_bus.pserver, req_on_bus.pcount,
                                            req_on_bus.pword, req_on_bus.widx,
                                            req_on_bus.query, req_on_bus.hash,
                                            req_on_bus.cmd});
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin : result_monitor
        t_map_resp want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result %h with no request outstanding", m_data);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data[1:0] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_data[1:0]);
                        errors++;
                    end
                    if (m_data[9:2] !== want.index) begin
                        $error("index: expected %0d, got %0d", want.index, m_data[9:2]);
                        errors++;
                    end
                    if (m_data[10] !== want.active) begin
                        $error("active: expected %0d, got %0d", want.active, m_data[10]);
                        errors++;
                    end
                    if (m_data[15:11] !== want.level) begin
                        $error("own_level: expected %0d, got %0d",
                               $signed(want.level), $signed(m_data[15:11]));
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int                   pick;
        logic [CMD_W-1:0]     c;
        logic [WORD_BITS-1:0] pw;
        logic [CNT_W-1:0]     p_cnt, p_own, p_init;
        foreach (map_words[i]) map_words[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: eight buckets, own bucket 0, one bucket active after init.
        send_idle = 15;
        recv_idle = 74;
        set_config(9'd8, 9'd0, 9'd1);
        push_req(OP_LOOKUP, '1, 9'd0, 3'd0, 32'd0, 9'd8, 9'h1FF);   // empty map misses
        push_req(OP_TEST, '0, 9'd0, 3'd0, 32'd0, 9'd8, 9'h1FF);
        push_req(OP_SPLIT, '0, 9'd0, 3'd0, 32'd0, 9'd8, 9'h1FF);    // no branch level yet
        push_req(OP_MERGE, '0, 9'd0, 3'd0, '1, 9'd8, 9'd0);         // peer is ourselves
        push_req(OP_MERGE, '0, 9'd0, 3'd0, '1, 9'd9, 9'h1FF);       // count mismatch
        push_req(OP_INIT, '0, 9'd0, 3'd0, 32'd0, 9'd0, 9'd0);
        push_req(OP_SPLIT, '0, 9'd0, 3'd0, 32'd0, 9'd0, 9'd0);
        push_req(OP_SPLIT, '0, 9'd0, 3'd0, 32'd0, 9'd0, 9'd0);
        push_req(OP_SPLIT, '0, 9'd0, 3'd0, 32'd0, 9'd0, 9'd0);
        push_req(OP_SPLIT, '0, 9'd0, 3'd0, 32'd0, 9'd0, 9'd0);      // level reached height
        push_req(OP_LOOKUP, '1, 9'd0, 3'd0, 32'd0, 9'd0, 9'd0);
        push_req(OP_LOOKUP, '0, 9'd0, 3'd0, 32'd0, 9'd0, 9'd0);
        push_req(OP_LOOKUP, 64'h8000_0000_0000_0006, 9'd0, 3'd0, 32'd0, 9'd0, 9'd0);
        push_req(OP_TEST, '0, 9'd4, 3'd0, 32'd0, 9'd0, 9'd0);
        push_req(OP_TEST, '0, 9'd8, 3'd0, 32'd0, 9'd0, 9'd0);        // at the count
        push_req(OP_TEST, '0, 9'h1FF, 3'd0, 32'd0, 9'd0, 9'd0);
        push_req(OP_MERGE, '0, 9'd0, 3'd7, '1, 9'd8, 9'h1FF);       // word beyond capacity
        push_req(OP_MERGE, '0, 9'd0, 3'd0, '1, 9'd8, 9'h1FF);       // sets bits past count
        push_req(OP_TEST, '0, 9'd31, 3'd0, 32'd0, 9'd0, 9'd0);
        push_req(OP_LOOKUP, '1, 9'd0, 3'd0, 32'd0, 9'd0, 9'd0);
        push_req(3'd5, '1, 9'h1FF, 3'd7, '1, 9'h1FF, 9'h1FF);
        push_req(3'd7, '1, 9'h1FF, 3'd7, '1, 9'h1FF, 9'h1FF);
        push_req(OP_INIT, '0, 9'd0, 3'd0, 32'd0, 9'd0, 9'd0);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 4) begin
                send_idle = 15;
                recv_idle = 74;
            end else if (p < 7) begin
                send_idle = 74;
                recv_idle = 15;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            case (p)
                0: begin p_cnt = 9'd8;   p_own = 9'd5;    p_init = 9'd2;   end // own bucket idle
                1: begin p_cnt = 9'd256; p_own = 9'd0;    p_init = 9'd1;   end
                2: begin p_cnt = 9'd256; p_own = 9'd255;  p_init = 9'd256; end
                3: begin p_cnt = 9'd1;   p_own = 9'h1FF;  p_init = 9'd0;   end // metadata server
                4: begin p_cnt = 9'd5;   p_own = 9'd1;    p_init = 9'd2;   end
                5: begin p_cnt = 9'd0;   p_own = 9'd0;    p_init = 9'd0;   end // count acts as one
                6: begin p_cnt = 9'd300; p_own = 9'd3;    p_init = 9'd4;   end // clamped count
                7: begin p_cnt = 9'd33;  p_own = 9'd7;    p_init = 9'd8;   end
                8: begin p_cnt = 9'd100; p_own = 9'h100;  p_init = 9'd511; end
                default: begin p_cnt = 9'd16; p_own = 9'd40; p_init = 9'd0; end // own past count
            endcase
            set_config(p_cnt, p_own, p_init);

            // Mostly well-formed traffic: an init first, then lookups, tests, splits
            // and merges from a matching peer, with some refused merges and odd opcodes.
            for (int k = 0; k < RUN_ITEMS; k++) begin
                pick = (k == 0) ? 0 : $urandom_range(0, 99);
                if (pick < 8)       c = OP_INIT;
                else if (pick < 30) c = OP_LOOKUP;
                else if (pick < 50) c = OP_TEST;
                else if (pick < 72) c = OP_SPLIT;
                else if (pick < 95) c = OP_MERGE;
                else                c = CMD_W'($urandom_range(5, 7));
                case ($urandom_range(0, 5))
                    0, 1, 2: pw = $urandom & $urandom & $urandom;
                    3:       pw = 32'd1 << $urandom_range(0, 31);
                    4:       pw = $urandom;
                    default: pw = '0;
                endcase
                push_req(c, {$urandom, $urandom},
                         ($urandom_range(0, 3) == 0) ? CNT_W'($urandom)
                                                     : CNT_W'($urandom_range(0, 256)),
                         WIDX_W'($urandom), pw,
                         ($urandom_range(0, 9) == 0) ? CNT_W'($urandom) : reg_count,
                         ($urandom_range(0, 14) == 0) ? reg_own : CNT_W'($urandom));
            end
            wait_drained();
        end

        if (errors == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/stbm_pkg.sv
hw/rtl/stbm_dp.sv
hw/rtl/stbm_ctrl.sv
hw/rtl/split_tree_bucket_map_top.sv
sim/tb_split_tree_bucket_map_top.sv
